/* hw/rtl/subarray_target_sum_counter_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the subarray target sum counter
// Concurrent checks on a clock and an active-low reset; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SUBARRAY_TARGET_SUM_COUNTER_UNIT_MACROS_SVH
`define SUBARRAY_TARGET_SUM_COUNTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define STSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset
`define STSC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define STSC_ASSERT(label, clk, rst_n, prop, msg)
`define STSC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* hw/rtl/stsc_pkg.sv */
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared constants, table entry layout and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package stsc_pkg;

	localparam int MAX_LEN    = 1024;
	localparam int ITEM_W     = $clog2(MAX_LEN + 1);
	localparam int TABLE_BITS = 10;
	localparam int SLOTS      = 1 << TABLE_BITS;
	localparam int SAMPLE_W   = 16;
	localparam int KEY_W      = 32;
	localparam int COUNT_W    = 20;
	localparam int FREQ_W     = 11;
	localparam int EPOCH_W    = 8;

	localparam logic [KEY_W-1:0]   HASH_MULT = 32'd2654435761;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [FREQ_W-1:0]  FREQ_MAX  = {FREQ_W{1'b1}};

	// One hash table slot; valid when its epoch matches the current one
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [KEY_W-1:0]   key;
		logic [FREQ_W-1:0]  freq;
	} entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;      // take sample, advance prefix sum
		logic load_diff;   // key = sum - target
		logic hash;        // slot address from key, restart probe
		logic read;        // read slot at probe address
		logic probe_next;  // advance to next slot
		logic count_upd;   // add matches to count, key = sum
		logic write_entry; // insert or bump current sum
		logic set_ovf;     // table full for current sum
		logic finish;      // load result register, clear on last
		logic clr_write;   // clearing pass: zero one slot
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_range;
		logic hit;
		logic free;
		logic exhausted;
		logic out_free;
		logic last;
		logic epoch_wrap;
		logic clr_last;
	} status_t;

endpackage

`default_nettype wire

/* hw/rtl/stsc_ctrl.sv */
// ----------------------------------------------------------------------------
// stsc_ctrl
// Sequencer: two hashed lookups per sample within capacity, result load and table clearing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "subarray_target_sum_counter_unit_macros.svh"

module stsc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  stsc_pkg::status_t st,
	output stsc_pkg::cmd_t    cmd
);
	import stsc_pkg::*;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_KEY1   = 4'd2;
	localparam logic [3:0] S_HASH1  = 4'd3;
	localparam logic [3:0] S_READ1  = 4'd4;
	localparam logic [3:0] S_CHK1   = 4'd5;
	localparam logic [3:0] S_HASH2  = 4'd6;
	localparam logic [3:0] S_READ2  = 4'd7;
	localparam logic [3:0] S_CHK2   = 4'd8;
	localparam logic [3:0] S_FINISH = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_KEY1;
				end
			end
			S_KEY1: begin
				cmd.load_diff = 1'b1;
				state_d       = st.in_range ? S_HASH1 : S_FINISH;
			end
			S_HASH1: begin
				cmd.hash = 1'b1;
				state_d  = S_READ1;
			end
			S_READ1: begin
				cmd.read = 1'b1;
				state_d  = S_CHK1;
			end
			S_CHK1: begin
				if (st.hit || st.free || st.exhausted) begin
					cmd.count_upd = 1'b1;
					state_d       = S_HASH2;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_READ1;
				end
			end
			S_HASH2: begin
				cmd.hash = 1'b1;
				state_d  = S_READ2;
			end
			S_READ2: begin
				cmd.read = 1'b1;
				state_d  = S_CHK2;
			end
			S_CHK2: begin
				if (st.hit || st.free) begin
					cmd.write_entry = 1'b1;
					state_d         = S_FINISH;
				end else if (st.exhausted) begin
					cmd.set_ovf = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_READ2;
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = (st.last && st.epoch_wrap) ? S_CLEAR : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state; reset starts with a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`STSC_ASSERT(a_accept_starts_item, clk, arst_n, (in_valid && !in_stall) |=> (state_q == S_KEY1), "accepted item did not start lookup")
	`STSC_ASSERT(a_finish_returns, clk, arst_n, cmd.finish |=> (state_q == S_IDLE || state_q == S_CLEAR), "finish did not end the item")

endmodule

`default_nettype wire

/* hw/rtl/stsc_dpath.sv */
// ----------------------------------------------------------------------------
// stsc_dpath
// Prefix sum, hashed frequency table, match counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "subarray_target_sum_counter_unit_macros.svh"

module stsc_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                target_sum_wr_en,
	input  logic signed [stsc_pkg::KEY_W-1:0]   target_sum_wr_data,
	input  logic signed [stsc_pkg::SAMPLE_W-1:0] sample,
	input  logic                                is_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [stsc_pkg::COUNT_W-1:0]        match_count,
	output logic                                end_of_array,
	output logic                                overflow,
	input  stsc_pkg::cmd_t                      cmd,
	output stsc_pkg::status_t                   st
);
	import stsc_pkg::*;

	localparam int CSUM_W = COUNT_W + 1;

	// Array state and configuration
	logic [KEY_W-1:0]      target_q;
	logic [KEY_W-1:0]      sum_q;
	logic [COUNT_W-1:0]    count_q;
	logic [ITEM_W-1:0]     items_q;
	logic                  ovf_q;
	logic [EPOCH_W-1:0]    epoch_q;
	logic [TABLE_BITS-1:0] clr_idx_q;
	logic                  out_valid_q;

	// Per-item working registers
	logic                  last_q;
	logic                  rng_q;
	logic [KEY_W-1:0]      key_q;
	logic [TABLE_BITS-1:0] addr_q;
	logic [TABLE_BITS-1:0] probe_q;
	entry_t                rd_q;
	logic [COUNT_W-1:0]    res_count_q;
	logic                  res_last_q;
	logic                  res_ovf_q;

	entry_t mem_q [SLOTS];

	logic [KEY_W-1:0]  sample_ext;
	logic [KEY_W-1:0]  prod;
	logic              slot_valid;
	logic              eq;
	logic [CSUM_W-1:0] count_sum;
	logic [FREQ_W-1:0] freq_inc;
	entry_t            wr_entry;

	assign sample_ext = {{(KEY_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
	assign prod       = key_q * HASH_MULT;
	assign slot_valid = (rd_q.epoch == epoch_q);
	assign eq         = (sum_q == target_q);
	assign freq_inc   = (rd_q.freq == FREQ_MAX) ? rd_q.freq : rd_q.freq + 1'b1;

	// Add the run hitting the target plus earlier prefix matches, saturate
	always_comb begin
		count_sum = {1'b0, count_q} + CSUM_W'(eq)
			+ (st.hit ? CSUM_W'(rd_q.freq) : CSUM_W'(0));
	end

	// Bump an existing key or start a new one
	always_comb begin
		wr_entry.epoch = epoch_q;
		wr_entry.key   = key_q;
		wr_entry.freq  = st.hit ? freq_inc : FREQ_W'(1);
	end

	// Status to controller
	always_comb begin
		st.in_range   = rng_q;
		st.hit        = slot_valid && (rd_q.key == key_q);
		st.free       = !slot_valid;
		st.exhausted  = slot_valid && (rd_q.key != key_q) && (probe_q == {TABLE_BITS{1'b1}});
		st.out_free   = !out_valid_q || !out_stall;
		st.last       = last_q;
		st.epoch_wrap = (epoch_q == {EPOCH_W{1'b1}});
		st.clr_last   = (clr_idx_q == {TABLE_BITS{1'b1}});
	end

	// Array state, config register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			items_q     <= '0;
			ovf_q       <= 1'b0;
			epoch_q     <= EPOCH_W'(1);
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (target_sum_wr_en) begin
				target_q <= target_sum_wr_data;
			end
			if (cmd.accept) begin
				if (items_q < ITEM_W'(MAX_LEN)) begin
					sum_q   <= sum_q + sample_ext;
					items_q <= items_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.count_upd) begin
				count_q <= count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.clr_write) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (st.clr_last) begin
					epoch_q <= EPOCH_W'(1);
				end
			end
			// Drop the result on transfer, refill on finish
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					sum_q   <= '0;
					count_q <= '0;
					items_q <= '0;
					ovf_q   <= 1'b0;
					epoch_q <= epoch_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			last_q <= is_last;
			rng_q  <= (items_q < ITEM_W'(MAX_LEN));
		end
		if (cmd.load_diff) begin
			key_q <= sum_q - target_q;
		end
		if (cmd.count_upd) begin
			key_q <= sum_q;
		end
		if (cmd.hash) begin
			addr_q  <= prod[KEY_W-1 -: TABLE_BITS];
			probe_q <= '0;
		end
		if (cmd.probe_next) begin
			addr_q  <= addr_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
		if (cmd.finish) begin
			res_count_q <= count_q;
			res_last_q  <= last_q;
			res_ovf_q   <= ovf_q;
		end
	end

	// Hash table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_write) begin
			mem_q[clr_idx_q] <= '0;
		end else if (cmd.write_entry) begin
			mem_q[addr_q] <= wr_entry;
		end
		if (cmd.read) begin
			rd_q <= mem_q[addr_q];
		end
	end

	assign out_valid    = out_valid_q;
	assign match_count  = res_count_q;
	assign end_of_array = res_last_q;
	assign overflow     = res_ovf_q;

	`STSC_ASSERT_NEVER(a_no_result_overwrite, clk, arst_n, cmd.finish && out_valid_q && out_stall, "result overwritten while stalled")
	`STSC_ASSERT_NEVER(a_items_bounded, clk, arst_n, items_q > ITEM_W'(MAX_LEN), "item counter beyond capacity")

endmodule

`default_nettype wire

/* hw/rtl/subarray_target_sum_counter_unit.sv */
// ----------------------------------------------------------------------------
// subarray_target_sum_counter_unit
// Counts contiguous runs of samples summing to a target, per array.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one signed sample and is_last.
//   Output channel (out_valid/out_stall) returns one result per sample: the
//   running match count, the is_last echo and the sticky overflow flag.
//   target_sum is written through target_sum_wr_en/target_sum_wr_data while
//   the block is idle.
// Sequence:
//   An item runs key load, hash, read and check for the difference, then hash,
//   read and check for the sum, then finish; each further slot probed adds a
//   read and a check. Items past capacity skip the table and go from key load
//   straight to finish. The next sample is taken at the earliest in the cycle
//   after the result loads, so no new sample is taken before the last one has
//   its result loaded; a second result waits until the first is transferred.
// Reset:
//   After reset, and after every 255th array end, a clearing pass writes all
//   1024 table slots, one per cycle; in_stall stays high for those cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module subarray_target_sum_counter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 target_sum_wr_en,
	input  logic signed [stsc_pkg::KEY_W-1:0]    target_sum_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [stsc_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [stsc_pkg::COUNT_W-1:0]         match_count,
	output logic                                 end_of_array,
	output logic                                 overflow
);
	import stsc_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Sequencer
	stsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Sums, table and result register
	stsc_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.target_sum_wr_en   (target_sum_wr_en),
		.target_sum_wr_data (target_sum_wr_data),
		.sample             (sample),
		.is_last            (is_last),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.match_count        (match_count),
		.end_of_array       (end_of_array),
		.overflow           (overflow),
		.cmd                (cmd),
		.st                 (st)
	);

endmodule

`default_nettype wire

/* tb/subarray_target_sum_counter_unit_test.sv */
// ----------------------------------------------------------------------------
// subarray_target_sum_counter_unit_test
// Self-checking bench for the target sum run counter. Samples go in through
// the valid/stall input channel with random gaps, results come back through
// the output channel under random stall, and each result is compared with a
// local prefix-sum and hash-table model of the block. Covers field extremes,
// wrapping differences, clustered hash probes, array capacity overflow and
// many short arrays under changing target settings.
// ----------------------------------------------------------------------------

module subarray_target_sum_counter_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	import stsc_pkg::*;

	localparam int QUIET_LIMIT   = 20000; // cycles with no transfer on either side
	localparam int SETTLE_CYCLES = 16;    // idle time before a target write
	localparam int TAIL_CYCLES   = 32;    // idle time before the verdict
	localparam int RANDOM_ITEMS  = 900;
	localparam int PHASE_ITEMS   = 110;
	localparam int CLUSTER_LEN   = 40;
	localparam logic [TABLE_BITS-1:0] CLUSTER_HOME = 10'd1021; // chain wraps past slot 1023

	// One expected result
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               eoa;
		logic               ovf;
	} run_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       target_sum_wr_en;
	logic signed [KEY_W-1:0]    target_sum_wr_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       is_last;
	logic                       out_valid;
	logic                       out_stall;
	logic [COUNT_W-1:0]         match_count;
	logic                       end_of_array;
	logic                       overflow;

	// Model state of the block
	logic [KEY_W-1:0]   tgt_sum;
	logic [KEY_W-1:0]   acc_sum;
	int unsigned        hit_total;
	int unsigned        taken_cnt;
	bit                 ovf_flag;
	bit                 tab_used [SLOTS];
	logic [KEY_W-1:0]   tab_key  [SLOTS];
	logic [FREQ_W-1:0]  tab_freq [SLOTS];

	run_result_t pending_q[$];
	int          err_cnt = 0;
	int          quiet_cycles = 0;
	bit          tx_idle = 1'b0;
	bit          rx_idle = 1'b0;
	int          stall_left = 0;

	subarray_target_sum_counter_unit u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.target_sum_wr_en   (target_sum_wr_en),
		.target_sum_wr_data (target_sum_wr_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.sample             (sample),
		.is_last            (is_last),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.match_count        (match_count),
		.end_of_array       (end_of_array),
		.overflow           (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Drop all per-array state, table included
	function automatic void clear_array();
		int i;
		acc_sum   = '0;
		hit_total = 0;
		taken_cnt = 0;
		ovf_flag  = 1'b0;
		for (i = 0; i < SLOTS; i++)
			tab_used[i] = 1'b0;
	endfunction

	// Multiplicative hash: top bits of key times the golden ratio constant
	function automatic logic [TABLE_BITS-1:0] home_slot(input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] prod;
		prod = key * HASH_MULT;
		return prod[KEY_W-1 -: TABLE_BITS];
	endfunction

	// Linear probe: matching slot, else first free slot, else -1
	function automatic int lookup_slot(input logic [KEY_W-1:0] key, output bit found);
		logic [TABLE_BITS-1:0] s;
		int i;
		s = home_slot(key);
		found = 1'b0;
		for (i = 0; i < SLOTS; i++) begin
			if (!tab_used[s])
				return int'(s);
			if (tab_key[s] == key) begin
				found = 1'b1;
				return int'(s);
			end
			s = s + 1'b1;
		end
		return -1;
	endfunction

	// Advance the model by one accepted sample and return its result
	function automatic run_result_t predict_count(input logic [SAMPLE_W-1:0] smp,
			input logic lst);
		run_result_t res;
		logic [KEY_W-1:0] diff;
		bit found;
		int slot;
		int unsigned add;
		if (taken_cnt < MAX_LEN) begin
			taken_cnt++;
			acc_sum = acc_sum + {{(KEY_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
			add = (acc_sum == tgt_sum) ? 1 : 0;
			diff = acc_sum - tgt_sum;
			slot = lookup_slot(diff, found);
			if (found)
				add += 32'(tab_freq[slot]);
			if (hit_total + add > 32'(COUNT_MAX))
				hit_total = 32'(COUNT_MAX);
			else
				hit_total = hit_total + add;
			slot = lookup_slot(acc_sum, found);
			if (slot < 0) begin
				ovf_flag = 1'b1;
			end else if (found) begin
				if (tab_freq[slot] != FREQ_MAX)
					tab_freq[slot] = tab_freq[slot] + 1'b1;
			end else begin
				tab_used[slot] = 1'b1;
				tab_key[slot]  = acc_sum;
				tab_freq[slot] = FREQ_W'(1);
			end
		end else begin
			ovf_flag = 1'b1;
		end
		res.count = hit_total[COUNT_W-1:0];
		res.eoa   = lst;
		res.ovf   = ovf_flag;
		if (lst)
			clear_array();
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stall and check each transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		int gap;
		run_result_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					$display("%0t: result with none expected: count %0d eoa %0b ovf %0b",
						$time, match_count, end_of_array, overflow);
					err_cnt++;
				end else begin
					want = pending_q.pop_front();
					if (match_count !== want.count) begin
						$display("%0t: match_count mismatch: expected %0d, actual %0d",
							$time, want.count, match_count);
						err_cnt++;
					end
					if (end_of_array !== want.eoa) begin
						$display("%0t: end_of_array mismatch: expected %0b, actual %0b",
							$time, want.eoa, end_of_array);
						err_cnt++;
					end
					if (overflow !== want.ovf) begin
						$display("%0t: overflow mismatch: expected %0b, actual %0b",
							$time, want.ovf, overflow);
						err_cnt++;
					end
				end
				gap = rx_idle ? $urandom_range(0, 15) : 0;
				stall_left <= gap;
				out_stall  <= (gap != 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= (stall_left > 1);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, QUIET_LIMIT, pending_q.size());
				$display("subarray_target_sum_counter_unit_test: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------

	// Offer one sample, hold it until the transfer, then record its result
	task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic lst);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= smp;
		is_last  <= lst;
		do @(posedge clk); while (in_stall);
		pending_q.push_back(predict_count(smp, lst));
	endtask

	// Hold off new samples until every outstanding result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	// Write the target while the block is idle
	task automatic set_target(input logic [KEY_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		target_sum_wr_en   <= 1'b1;
		target_sum_wr_data <= value;
		@(posedge clk);
		target_sum_wr_en <= 1'b0;
		tgt_sum = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Sample extremes, single-item array, wrapping differences
	task automatic test_directed_extremes();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		// target still at its reset value of zero
		send_item(16'h0000, 1'b0);
		send_item(16'h7FFF, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'h0001, 1'b0);
		send_item(16'h0000, 1'b1);
		// an array of one item
		send_item(16'h0000, 1'b1);
		set_target(32'h7FFF_FFFF);
		send_item(16'h7FFF, 1'b0);
		send_item(16'h8000, 1'b1);
		set_target(32'h8000_0000);
		send_item(16'h8000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h7FFF, 1'b1);
		set_target(32'd3);
		send_item(16'd3, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'hFFFD, 1'b0);
		send_item(16'd3, 1'b0);
		send_item(16'd3, 1'b1);
		set_target(32'hFFFF_FFFD);
		send_item(16'hFFFD, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd3, 1'b0);
		send_item(16'hFFFD, 1'b1);
	endtask

	// Prefix sums picked to share two home slots: long probe chains that wrap
	task automatic test_probe_collisions();
		logic [KEY_W-1:0]      plan_sum;
		logic [SAMPLE_W-1:0]   smp;
		logic [TABLE_BITS-1:0] rel;
		int n;
		int tries;
		bit placed;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		set_target(32'd0);
		plan_sum = '0;
		for (n = 0; n < CLUSTER_LEN; n++) begin
			smp = '0;
			// a zero sample repeats the sum and hits deep in the chain
			if ($urandom_range(0, 4) != 0) begin
				placed = 1'b0;
				for (tries = 0; tries < 50000 && !placed; tries++) begin
					smp = SAMPLE_W'($urandom_range(0, 16'hFFFF));
					rel = home_slot(plan_sum + {{(KEY_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp})
						- CLUSTER_HOME;
					placed = (rel < 2);
				end
				if (!placed)
					smp = '0;
			end
			plan_sum = plan_sum + {{(KEY_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
			send_item(smp, n == CLUSTER_LEN - 1);
		end
	endtask

	// Fill an array to capacity, then feed ignored items, then a fresh array
	task automatic test_capacity_overflow();
		int n;
		rx_idle = 1'b1;
		set_target(32'd0);
		for (n = 0; n < MAX_LEN; n++) begin
			tx_idle = ((n / 128) % 2) != 0;
			send_item(16'h0000, 1'b0);
		end
		for (n = 0; n < 6; n++)
			send_item(SAMPLE_W'($urandom_range(0, 16'hFFFF)), n == 5);
		send_item(16'h0000, 1'b0);
		send_item(16'h0000, 1'b1);
	endtask

	// Many short arrays over a range of targets, sample mixes and idling
	task automatic test_random_arrays();
		logic [KEY_W-1:0]    tv;
		logic [SAMPLE_W-1:0] smp;
		int phase;
		int sent;
		int phase_sent;
		int len;
		int i;
		int mix;
		sent = 0;
		for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
			case (phase % 6)
				0: tv = 32'd0;
				1: tv = $urandom_range(0, 16) - 8;
				2: tv = ((phase % 12) == 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
				3: tv = $urandom();
				4: tv = $urandom_range(0, 80000) - 40000;
				default: tv = $urandom_range(0, 6) - 3;
			endcase
			set_target(tv);
			mix = $urandom_range(0, 2);
			tx_idle = ($urandom_range(0, 1) != 0);
			rx_idle = ($urandom_range(0, 1) != 0);
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
				len = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
				for (i = 0; i < len; i++) begin
					if ($urandom_range(0, 63) == 0)
						drain_results();
					// small values repeat sums and hit the target; full range covers every bit
					case (mix)
						0: smp = ($urandom_range(0, 15) == 0) ?
							SAMPLE_W'($urandom_range(0, 16'hFFFF)) :
							SAMPLE_W'($urandom_range(0, 8) - 4);
						1: smp = SAMPLE_W'($urandom_range(0, 16'hFFFF));
						default: begin
							case ($urandom_range(0, 7))
								0: smp = 16'h7FFF;
								1: smp = 16'h8000;
								2, 3: smp = SAMPLE_W'($urandom_range(0, 16'hFFFF));
								default: smp = SAMPLE_W'($urandom_range(0, 4) - 2);
							endcase
						end
					endcase
					send_item(smp, i == len - 1);
				end
				sent += len;
				phase_sent += len;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		target_sum_wr_en   = 1'b0;
		target_sum_wr_data = '0;
		in_valid           = 1'b0;
		sample             = '0;
		is_last            = 1'b0;
		tgt_sum            = '0;
		clear_array();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_probe_collisions();
		test_capacity_overflow();
		test_random_arrays();

		// wait out the last results, then let the block settle
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("subarray_target_sum_counter_unit_test: clean");
		else
			$display("subarray_target_sum_counter_unit_test: errors");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/stsc_pkg.sv
hw/rtl/stsc_ctrl.sv
hw/rtl/stsc_dpath.sv
hw/rtl/subarray_target_sum_counter_unit.sv
tb/subarray_target_sum_counter_unit_test.sv
